/* sv/bvm_pkg.sv */
`timescale 1ns / 1ps

package bvm_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int MV_W       = 16;
    localparam int CFG_MV_W   = 14;
    localparam int GAIN_W     = 16;
    localparam int PCT_W      = 7;
    localparam int Q_FRAC     = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd3;

    // Register reset values
    localparam logic [CFG_MV_W-1:0] FULL_MV_RST   = 14'd3200;
    localparam logic [CFG_MV_W-1:0] EMPTY_MV_RST  = 14'd2000;
    localparam logic [CFG_MV_W-1:0] CUTOFF_MV_RST = 14'd2100;
    localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'd12811;
    localparam logic [MV_W-1:0]     HELD_AVG_RST  = 16'd3200;

    // Percentage mapping
    localparam int                 PCT_SCALE = 100;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_MIN   = 7'd0;
    localparam int                 PCT_NUM_W = CFG_MV_W + PCT_W;

    // Shared divider step counts: the quotient of the average fits 16 bits,
    // the quotient of the percentage fits 7 bits.
    localparam int AVG_STEPS = MV_W;
    localparam int PCT_STEPS = PCT_W;
    localparam int DCNT_W    = 4;

    typedef struct packed {
        logic [ADC_W-1:0] adc_mv;
        logic             read_ok;
        logic             usb_powered;
    } t_in;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [MV_W-1:0]  average_mv;
        logic [PCT_W-1:0] charge_pct;
        logic             below_cutoff;
        logic             shutdown_request;
    } t_out;

    typedef struct packed {
        logic capture;
        logic scale;
        logic accum;
        logic avg_div_load;
        logic div_step;
        logic avg_save;
        logic pct_prep;
        logic pct_save;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic read_ok;
        logic sum_last;
        logic div_last;
        logic pct_divide;
    } t_dp_sts;

endpackage

/* sv/bvm_datapath.sv */
`timescale 1ns / 1ps

module bvm_datapath #(
    parameter int WINDOW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bvm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bvm_pkg::t_in                  i_in_data,
    input  bvm_pkg::t_dp_cmd              i_cmd,
    output bvm_pkg::t_dp_sts              o_sts,
    output bvm_pkg::t_out                 o_out_data
);
    import bvm_pkg::*;

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = MV_W + CNT_W;
    localparam int DW     = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
    localparam int PROD_W = ADC_W + GAIN_W;

    logic [CFG_MV_W-1:0] r_full_mv;
    logic [CFG_MV_W-1:0] r_empty_mv;
    logic [CFG_MV_W-1:0] r_cutoff_mv;
    logic [GAIN_W-1:0]   r_gain;

    t_in                 r_in;
    logic [MV_W-1:0]     r_batt;
    logic [MV_W-1:0]     r_ring [WINDOW];
    logic [IDX_W-1:0]    r_slot;
    logic                r_ring_full;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_W-1:0]    r_acc;

    logic [DW-1:0]       r_rem;
    logic [DW-1:0]       r_dsh;
    logic [MV_W-1:0]     r_quo;
    logic [DCNT_W-1:0]   r_dcnt;

    logic [MV_W-1:0]     r_held_avg;
    logic [PCT_W-1:0]    r_held_pct;
    t_out                r_out;

    logic [PROD_W-1:0]       w_prod;
    logic [MV_W-1:0]         w_batt;
    logic                    w_ge;
    logic [CFG_MV_W-1:0]     w_span;
    logic [CFG_MV_W-1:0]     w_diff;
    logic [PCT_NUM_W-1:0]    w_pct_num;
    logic                    w_no_span;
    logic                    w_at_full;
    logic                    w_at_empty;
    logic                    w_in_range;
    logic [PCT_W-1:0]        w_clamp_pct;
    logic                    w_low;

    assign w_prod = PROD_W'(r_in.adc_mv) * PROD_W'(r_gain);
    assign w_batt = w_prod[Q_FRAC +: MV_W];

    assign w_ge = (r_rem >= r_dsh);

    // The difference fits 14 bits whenever the average lies strictly inside the span.
    assign w_span      = r_full_mv - r_empty_mv;
    assign w_diff      = r_held_avg[CFG_MV_W-1:0] - r_empty_mv;
    assign w_pct_num   = PCT_NUM_W'(w_diff) * PCT_NUM_W'(PCT_SCALE);
    assign w_no_span   = (r_full_mv <= r_empty_mv);
    assign w_at_full   = (r_held_avg >= MV_W'(r_full_mv));
    assign w_at_empty  = (r_held_avg <= MV_W'(r_empty_mv));
    assign w_in_range  = !w_no_span && !w_at_full && !w_at_empty;
    assign w_clamp_pct = (!w_no_span && w_at_full) ? PCT_MAX : PCT_MIN;
    assign w_low       = (r_held_avg <= MV_W'(r_cutoff_mv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_mv   <= FULL_MV_RST;
            r_empty_mv  <= EMPTY_MV_RST;
            r_cutoff_mv <= CUTOFF_MV_RST;
            r_gain      <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FULL_MV:  r_full_mv   <= i_cfg_data[CFG_MV_W-1:0];
                CFG_EMPTY_MV: r_empty_mv  <= i_cfg_data[CFG_MV_W-1:0];
                CFG_CUTOFF:   r_cutoff_mv <= i_cfg_data[CFG_MV_W-1:0];
                CFG_GAIN:     r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Ring storage has no reset; only written entries are ever summed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_ring[r_slot] <= w_batt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_ring_full <= 1'b0;
            r_held_avg  <= HELD_AVG_RST;
            r_held_pct  <= PCT_MIN;
        end else begin
            if (i_cmd.scale) begin
                if (r_slot == IDX_W'(WINDOW - 1)) begin
                    r_slot      <= '0;
                    r_ring_full <= 1'b1;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (i_cmd.avg_save) begin
                r_held_avg <= r_quo;
            end
            if (i_cmd.pct_prep && !w_in_range) begin
                r_held_pct <= w_clamp_pct;
            end
            if (i_cmd.pct_save) begin
                r_held_pct <= r_quo[PCT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in   <= i_in_data;
            r_batt <= '0;
        end
        if (i_cmd.scale) begin
            r_batt <= w_batt;
            r_acc  <= '0;
            r_idx  <= '0;
            if (r_slot == IDX_W'(WINDOW - 1) || r_ring_full) begin
                r_count <= CNT_W'(WINDOW);
            end else begin
                r_count <= CNT_W'(r_slot) + 1'b1;
            end
        end
        if (i_cmd.accum) begin
            r_acc <= r_acc + SUM_W'(r_ring[r_idx]);
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.avg_div_load) begin
            r_rem  <= DW'(r_acc);
            r_dsh  <= DW'(r_count) << (AVG_STEPS - 1);
            r_quo  <= '0;
            r_dcnt <= DCNT_W'(AVG_STEPS - 1);
        end
        if (i_cmd.pct_prep && w_in_range) begin
            r_rem  <= DW'(w_pct_num);
            r_dsh  <= DW'(w_span) << (PCT_STEPS - 1);
            r_quo  <= '0;
            r_dcnt <= DCNT_W'(PCT_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo  <= {r_quo[MV_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.battery_mv       <= r_batt;
            r_out.average_mv       <= r_held_avg;
            r_out.charge_pct       <= r_held_pct;
            r_out.below_cutoff     <= w_low;
            r_out.shutdown_request <= r_in.read_ok && w_low && !r_in.usb_powered;
        end
    end

    always_comb begin
        o_sts.read_ok    = r_in.read_ok;
        o_sts.sum_last   = (CNT_W'(r_idx) == (r_count - 1'b1));
        o_sts.div_last   = (r_dcnt == '0);
        o_sts.pct_divide = w_in_range;
    end

    assign o_out_data = r_out;

endmodule

/* sv/bvm_ctrl.sv */
`timescale 1ns / 1ps

module bvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bvm_pkg::t_dp_sts i_sts,
    output bvm_pkg::t_dp_cmd o_cmd
);
    import bvm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SCALE    = 11'b000_0000_0010,
        S_SUM      = 11'b000_0000_0100,
        S_AVG_LOAD = 11'b000_0000_1000,
        S_AVG_DIV  = 11'b000_0001_0000,
        S_AVG_SAVE = 11'b000_0010_0000,
        S_PCT_PREP = 11'b000_0100_0000,
        S_PCT_DIV  = 11'b000_1000_0000,
        S_PCT_SAVE = 11'b001_0000_0000,
        S_FINISH   = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCALE;
                end
            end
            S_SCALE: begin
                if (i_sts.read_ok) begin
                    o_cmd.scale = 1'b1;
                    n_state     = S_SUM;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SUM: begin
                o_cmd.accum = 1'b1;
                if (i_sts.sum_last) begin
                    n_state = S_AVG_LOAD;
                end
            end
            S_AVG_LOAD: begin
                o_cmd.avg_div_load = 1'b1;
                n_state            = S_AVG_DIV;
            end
            S_AVG_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_AVG_SAVE;
                end
            end
            S_AVG_SAVE: begin
                o_cmd.avg_save = 1'b1;
                n_state        = S_PCT_PREP;
            end
            S_PCT_PREP: begin
                o_cmd.pct_prep = 1'b1;
                n_state        = i_sts.pct_divide ? S_PCT_DIV : S_FINISH;
            end
            S_PCT_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PCT_SAVE;
                end
            end
            S_PCT_SAVE: begin
                o_cmd.pct_save = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/battery_voltage_monitor_top.sv */
`timescale 1ns / 1ps
// A failed read skips scaling, summing and both divisions and goes straight to the result beat.
// A good read sums the filled ring entries (1 to WINDOW of them) and then runs the shared
// shift-subtract divider for the average (16 steps), then for the percentage (7 steps) unless it is clamped.
// One sample is handled at a time; the result beat waits until the output register is free.
// Reset is synchronous and active low; it restores the register defaults and empties the ring.

module battery_voltage_monitor_top #(
    parameter int WINDOW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bvm_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bvm_pkg::t_in                  i_in_data,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bvm_pkg::t_out                 o_out_data
);
    import bvm_pkg::*;

    // The controller sequences one sample at a time through scaling, summing the ring,
    // dividing for the average and, unless the percentage is clamped, dividing again
    // for the charge percentage. The datapath holds the configuration registers, the
    // sample ring, the accumulator, the divider and the output register.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The output register lets the controller go back to idle and take the next input
    // beat while the previous result beat still waits for the downstream side.
    bvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Scaling uses one 12 by 16 multiply; the percentage numerator uses a multiply by a
    // constant. Each product lands in a register before it is used again.
    bvm_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

    // Once a beat is taken the controller leaves idle, so the next cycle cannot take another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a sample is in progress");

    // A result is never written over one that the downstream side has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");

    // A shutdown request only comes with the low flag.
    a_shutdown_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.shutdown_request || o_out_data.below_cutoff))
        else $error("shutdown requested without the low flag");

    // The percentage stays within its range.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.charge_pct <= PCT_MAX))
        else $error("charge percentage above full");

endmodule
